// File: rtl/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and constants for the planar row stretch to mono pattern block.
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

   localparam int MAX_PLANES     = 4;
   localparam int PATTERN_COLORS = 16;
   localparam int PATTERN_DEPTH  = 128;

   // destination rows are clipped to this many bits
   localparam logic [14:0] DEST_LIMIT = 15'd16384;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_PIXEL = 2'd2,
      CMD_END   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_PLANE_COUNT   = 3'd0,
      REG_SOURCE_PIXELS = 3'd1,
      REG_DEST_PIXELS   = 3'd2,
      REG_BASE_REPEAT   = 3'd3,
      REG_REPEAT_STEP   = 3'd4
   } reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } state_type;

endpackage

`default_nettype wire

// File: rtl/prs_if.sv
// ----------------------------------------------------------------------------
// prs_req_if / prs_rsp_if
// Valid/ready channels for command words in and destination bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface prs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [6:0] pattern_index;
   logic [7:0] pattern_value;
   logic [2:0] row_phase;
   logic [3:0] plane_bits;

   modport source (output valid, cmd, pattern_index, pattern_value, row_phase,
                   plane_bits, input ready);
   modport sink   (input valid, cmd, pattern_index, pattern_value, row_phase,
                   plane_bits, output ready);
endinterface

interface prs_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [10:0] byte_index;
   logic        last;

   modport source (output valid, out_byte, byte_index, last, input ready);
   modport sink   (input valid, out_byte, byte_index, last, output ready);
endinterface

`default_nettype wire

// File: rtl/planar_row_stretch_to_mono_pattern_top.sv
// ----------------------------------------------------------------------------
// planar_row_stretch_to_mono_pattern_top
// Stretches a planar source row onto a 1 bpp destination row with a
// software-loaded 128-byte ordered dither pattern.
//
// Usage: software sets the row registers over the APB port and loads the
// pattern table with load words. A start-row word sets the row phase, then
// one pixel word per source pixel, then an end-row word flushes the partial
// byte. Completed destination bytes leave on rsp with their byte index;
// last marks the final byte caused by one input word.
// Load, start and end-row words take effect when taken; an end-row word
// that must flush a partial byte then passes through a flush state. A pixel
// word reads the pattern memory when taken, then merges its run one
// byte-aligned chunk per cycle, up to each byte boundary, unless rsp stalls it.
// The output byte sits in a register, so new words are taken while it
// waits; a stalled rsp only halts a run at the next completed byte.
// Reset clears all row state and restores register defaults; the pattern
// table holds no reset value and must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_row_stretch_to_mono_pattern_top (
   input  wire logic        clock,
   input  wire logic        reset,
   prs_req_if.sink          req,
   prs_rsp_if.source        rsp,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   // configuration
   logic [2:0]  pc_ff;
   logic [12:0] spx_ff;
   logic [14:0] dpx_ff;
   logic [5:0]  base_ff;
   logic [11:0] step_ff;

   // row state
   prs_pkg::state_type state_ff, state_in;
   logic [2:0]  phase_ff, phase_in;
   logic [11:0] rem_ff, rem_in;
   logic [12:0] spos_ff, spos_in;
   logic [14:0] dpos_ff, dpos_in;
   logic [7:0]  part_ff, part_in;
   logic [6:0]  rep_ff, rep_in;

   // output word register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic [10:0] rsp_index_ff, rsp_index_in;
   logic        rsp_last_ff, rsp_last_in;

   // pattern table
   logic [7:0]  pat_mem [prs_pkg::PATTERN_DEPTH];
   logic [7:0]  pat_rd_ff;
   logic [6:0]  rd_addr;

   logic        accept;
   logic        cfg_wr;
   prs_pkg::cmd_type cmd;
   logic [14:0] dw;
   logic        cfg_ok;
   logic [12:0] sum, sum_red;
   logic        wrap;
   logic [6:0]  rep_new;
   logic [4:0]  mask_full;
   logic [3:0]  color;
   logic        pix_go;
   logic [2:0]  off;
   logic [3:0]  room, n_a, n;
   logic [14:0] left, left_after, new_dpos;
   logic [6:0]  rep_after;
   logic [7:0]  mask_bits, merged;
   logic        completes, run_done, emit_last, can_emit, run_stall;
   logic [11:0] idx_plus;
   logic [11:0] idx_minus;

   assign pready     = 1'b1;
   assign req.ready  = (state_ff == prs_pkg::ST_IDLE);
   assign accept     = req.valid && req.ready;
   assign cmd        = prs_pkg::cmd_type'(req.cmd);
   assign cfg_wr     = psel && penable && pwrite && pready;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_byte   = rsp_byte_ff;
   assign rsp.byte_index = rsp_index_ff;
   assign rsp.last       = rsp_last_ff;

   // ---------------- configuration port ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= 3'd1;
         spx_ff  <= '0;
         dpx_ff  <= '0;
         base_ff <= 6'd1;
         step_ff <= '0;
      end else if (cfg_wr) begin
         unique case (prs_pkg::reg_type'(paddr[4:2]))
            prs_pkg::REG_PLANE_COUNT:   pc_ff   <= pwdata[2:0];
            prs_pkg::REG_SOURCE_PIXELS: spx_ff  <= pwdata[12:0];
            prs_pkg::REG_DEST_PIXELS:   dpx_ff  <= pwdata[14:0];
            prs_pkg::REG_BASE_REPEAT:   base_ff <= pwdata[5:0];
            prs_pkg::REG_REPEAT_STEP:   step_ff <= pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (prs_pkg::reg_type'(paddr[4:2]))
         prs_pkg::REG_PLANE_COUNT:   prdata = {29'd0, pc_ff};
         prs_pkg::REG_SOURCE_PIXELS: prdata = {19'd0, spx_ff};
         prs_pkg::REG_DEST_PIXELS:   prdata = {17'd0, dpx_ff};
         prs_pkg::REG_BASE_REPEAT:   prdata = {26'd0, base_ff};
         prs_pkg::REG_REPEAT_STEP:   prdata = {20'd0, step_ff};
         default:                    prdata = '0;
      endcase
   end

   // ---------------- pixel setup ----------------
   assign dw     = (dpx_ff > prs_pkg::DEST_LIMIT) ? prs_pkg::DEST_LIMIT : dpx_ff;
   assign cfg_ok = (pc_ff != 3'd0) && (pc_ff <= 3'(prs_pkg::MAX_PLANES)) &&
                   (spx_ff != 13'd0);

   // Bresenham remainder, reduced at most once
   assign sum     = {1'b0, rem_ff} + {1'b0, step_ff};
   assign wrap    = (sum >= spx_ff);
   assign sum_red = wrap ? (sum - spx_ff) : sum;
   assign rep_new = {1'b0, base_ff} + {6'd0, wrap};

   assign mask_full = (5'd1 << pc_ff) - 5'd1;
   assign color     = req.plane_bits & mask_full[3:0];
   assign rd_addr   = {phase_ff, color};
   assign pix_go    = cfg_ok && (spos_ff < spx_ff) && (dpos_ff < dw);

   // ---------------- run chunk: up to the next byte boundary ----------------
   assign off       = dpos_ff[2:0];
   assign room      = 4'd8 - {1'b0, off};
   assign left      = dw - dpos_ff;
   assign n_a       = ({3'd0, room} > rep_ff) ? rep_ff[3:0] : room;
   assign n         = (left < {11'd0, n_a}) ? left[3:0] : n_a;
   assign new_dpos  = dpos_ff + {11'd0, n};
   assign rep_after = rep_ff - {3'd0, n};
   assign left_after = dw - new_dpos;
   assign mask_bits = (8'hFF >> off) & ~(8'hFF >> ({1'b0, off} + n));
   assign merged    = part_ff | (pat_rd_ff & mask_bits);
   assign completes = (new_dpos[2:0] == 3'd0);
   assign run_done  = (rep_after == 7'd0) || (new_dpos >= dw);
   // no further byte can complete once fewer than 8 bits remain
   assign emit_last = (rep_after < 7'd8) || (left_after < 15'd8);
   assign can_emit  = !rsp_valid_ff || rsp.ready;
   assign run_stall = completes && !can_emit;
   assign idx_minus = new_dpos[14:3] - 12'd1;
   assign idx_plus  = dpos_ff[14:3] + 12'd1;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prs_pkg::ST_IDLE: begin
            if (accept) begin
               if (cmd == prs_pkg::CMD_PIXEL && pix_go && rep_new != 7'd0)
                  state_in = prs_pkg::ST_RUN;
               else if (cmd == prs_pkg::CMD_END && cfg_ok && off != 3'd0)
                  state_in = prs_pkg::ST_FLUSH;
            end
         end
         prs_pkg::ST_RUN: begin
            if (!run_stall && run_done) state_in = prs_pkg::ST_IDLE;
         end
         prs_pkg::ST_FLUSH: begin
            if (can_emit) state_in = prs_pkg::ST_IDLE;
         end
         default: state_in = prs_pkg::ST_IDLE;
      endcase
   end

   // ---------------- datapath ----------------
   always_comb begin
      phase_in     = phase_ff;
      rem_in       = rem_ff;
      spos_in      = spos_ff;
      dpos_in      = dpos_ff;
      part_in      = part_ff;
      rep_in       = rep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         prs_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  prs_pkg::CMD_START: begin
                     phase_in = req.row_phase;
                     rem_in   = '0;
                     spos_in  = '0;
                     dpos_in  = '0;
                     part_in  = '0;
                  end
                  prs_pkg::CMD_PIXEL: begin
                     if (pix_go) begin
                        rem_in  = sum_red[11:0];
                        spos_in = spos_ff + 13'd1;
                        rep_in  = rep_new;
                     end
                  end
                  prs_pkg::CMD_END: begin
                     if (cfg_ok && off == 3'd0) begin
                        part_in = '0;
                        spos_in = spx_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         prs_pkg::ST_RUN: begin
            if (!run_stall) begin
               dpos_in = new_dpos;
               rep_in  = rep_after;
               part_in = completes ? 8'd0 : merged;
               if (completes) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = merged;
                  rsp_index_in = idx_minus[10:0];
                  rsp_last_in  = emit_last;
               end
            end
         end
         prs_pkg::ST_FLUSH: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = part_ff;
               rsp_index_in = dpos_ff[13:3];
               rsp_last_in  = 1'b1;
               dpos_in      = {idx_plus, 3'd0};
               part_in      = '0;
               spos_in      = spx_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prs_pkg::ST_IDLE;
         phase_ff     <= '0;
         rem_ff       <= '0;
         spos_ff      <= '0;
         dpos_ff      <= '0;
         part_ff      <= '0;
         rep_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rem_ff       <= rem_in;
         spos_ff      <= spos_in;
         dpos_ff      <= dpos_in;
         part_ff      <= part_in;
         rep_ff       <= rep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff  <= rsp_byte_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // pattern RAM: loads and pixel reads come from different words, never
   // the same cycle
   always_ff @(posedge clock) begin
      if (accept && cmd == prs_pkg::CMD_LOAD)
         pat_mem[req.pattern_index] <= req.pattern_value;
      if (accept && cmd == prs_pkg::CMD_PIXEL)
         pat_rd_ff <= pat_mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - planar row stretch to mono pattern
// Loads the dither table for two row phases, then runs directed rows at the
// register extremes and random rows of pixel, start, end and stray words. A
// local model predicts every destination byte as each word is accepted; a
// checker compares each byte as it leaves. Both channels idle at random, and
// the receiver also holds off for a long stretch so the block backs up.
// ----------------------------------------------------------------------------

module tb;

   typedef struct {
      prs_pkg::cmd_type cmd;
      logic [6:0]       pattern_index;
      logic [7:0]       pattern_value;
      logic [2:0]       row_phase;
      logic [3:0]       plane_bits;
   } req_word_type;

   typedef struct {
      logic [7:0]  out_byte;
      logic [10:0] byte_index;
      logic        last;
   } dest_byte_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   prs_req_if req_if ();
   prs_rsp_if rsp_if ();

   planar_row_stretch_to_mono_pattern_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // model copy of the block's registers and row state
   logic [7:0]  dither_tbl [0:prs_pkg::PATTERN_DEPTH-1];
   int unsigned plane_cfg     = 1;
   int unsigned src_width_cfg = 0;
   int unsigned dst_width_cfg = 0;
   int unsigned repeat_cfg    = 1;
   int unsigned step_cfg      = 0;
   int unsigned cur_phase     = 0;
   int unsigned stretch_rem   = 0;
   int unsigned src_count     = 0;
   int unsigned dst_bit       = 0;
   int unsigned acc_byte      = 0;

   dest_byte_type pending_bytes [$];

   int errors         = 0;
   int words_sent     = 0;
   int words_acting   = 0;
   int bytes_checked  = 0;
   int settings_count = 0;
   int req_idle_pct   = 37;
   int rsp_idle_pct   = 37;
   int rsp_hold_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic void flag_error(string msg);
      errors++;
      if (errors <= 10)
         $display("%s", msg);
   endfunction

   // the load test fills phases 0 and 7 of the table
   function automatic logic [2:0] loaded_phase(int unsigned arg);
      return arg[0] ? 3'd7 : 3'd0;
   endfunction

   // Works out the destination bytes one accepted word produces.
   function automatic void predict_dest_bytes(req_word_type w);
      dest_byte_type made [$];
      dest_byte_type b;
      int unsigned dw;
      int unsigned reps;
      int unsigned sum;
      int unsigned color;
      int unsigned pat;
      bit          cfg_ok;
      dw = (dst_width_cfg > prs_pkg::DEST_LIMIT) ? prs_pkg::DEST_LIMIT : dst_width_cfg;
      cfg_ok = plane_cfg != 0 && plane_cfg <= prs_pkg::MAX_PLANES && src_width_cfg != 0;
      case (w.cmd)
         prs_pkg::CMD_LOAD: begin
            dither_tbl[w.pattern_index] = w.pattern_value;
            words_acting++;
         end
         prs_pkg::CMD_START: begin
            cur_phase   = w.row_phase;
            stretch_rem = 0;
            src_count   = 0;
            dst_bit     = 0;
            acc_byte    = 0;
            words_acting++;
         end
         prs_pkg::CMD_PIXEL: begin
            if (cfg_ok && src_count < src_width_cfg && dst_bit < dw) begin
               words_acting++;
               reps = repeat_cfg;
               sum  = stretch_rem + step_cfg;
               // remainder wraps past the source width: one extra bit
               if (sum >= src_width_cfg) begin
                  reps++;
                  sum -= src_width_cfg;
               end
               stretch_rem = sum & 12'hfff;
               src_count   = (src_count + 1) & 13'h1fff;
               color = w.plane_bits & ((1 << plane_cfg) - 1) & 4'hf;
               pat   = dither_tbl[(cur_phase * prs_pkg::PATTERN_COLORS + color) & 7'h7f];
               while (reps > 0 && dst_bit < dw) begin
                  acc_byte |= pat & (8'h80 >> (dst_bit & 7));
                  dst_bit++;
                  reps--;
                  if ((dst_bit & 7) == 0) begin
                     b.out_byte   = acc_byte[7:0];
                     b.byte_index = 11'((dst_bit >> 3) - 1);
                     b.last       = 1'b0;
                     made.push_back(b);
                     acc_byte = 0;
                  end
               end
            end
         end
         prs_pkg::CMD_END: begin
            if (cfg_ok) begin
               words_acting++;
               if ((dst_bit & 7) != 0) begin
                  b.out_byte   = acc_byte[7:0];
                  b.byte_index = 11'(dst_bit >> 3);
                  b.last       = 1'b0;
                  made.push_back(b);
                  dst_bit = (dst_bit + 7) & ~32'd7;
               end
               acc_byte  = 0;
               src_count = src_width_cfg;
            end
         end
      endcase
      if (made.size() > 0)
         made[made.size()-1].last = 1'b1;
      foreach (made[i])
         pending_bytes.push_back(made[i]);
   endfunction

   function automatic req_word_type make_word(prs_pkg::cmd_type c);
      req_word_type w;
      w.cmd           = c;
      w.pattern_index = 7'($urandom);
      w.pattern_value = 8'($urandom);
      w.row_phase     = loaded_phase($urandom);
      w.plane_bits    = 4'($urandom);
      return w;
   endfunction

   task automatic send_word(req_word_type w);
      @(negedge clock);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.cmd           = w.cmd;
      req_if.pattern_index = w.pattern_index;
      req_if.pattern_value = w.pattern_value;
      req_if.row_phase     = w.row_phase;
      req_if.plane_bits    = w.plane_bits;
      req_if.valid         = 1'b1;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      words_sent++;
      predict_dest_bytes(w);
   endtask

   // arg lands in the field the command uses: phase for start (folded onto a
   // loaded phase), bits for pixel
   task automatic send_cmd(prs_pkg::cmd_type c, int unsigned arg);
      req_word_type w;
      w = make_word(c);
      if (c == prs_pkg::CMD_START)
         w.row_phase = loaded_phase(arg);
      else if (c == prs_pkg::CMD_PIXEL)
         w.plane_bits = arg[3:0];
      send_word(w);
   endtask

   task automatic send_row(int unsigned phase, int npix);
      send_cmd(prs_pkg::CMD_START, phase);
      repeat (npix) send_cmd(prs_pkg::CMD_PIXEL, $urandom);
      send_cmd(prs_pkg::CMD_END, 0);
   endtask

   // Sender stops until every predicted byte is out, then lets the block
   // finish any pixel still merging.
   task automatic wait_all_bytes();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_bytes.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic csr_write(prs_pkg::reg_type r, logic [31:0] v);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {r, 2'b00};
      pwdata  = v;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      case (r)
         prs_pkg::REG_PLANE_COUNT:   plane_cfg     = v & 32'h7;
         prs_pkg::REG_SOURCE_PIXELS: src_width_cfg = v & 32'h1fff;
         prs_pkg::REG_DEST_PIXELS:   dst_width_cfg = v & 32'h7fff;
         prs_pkg::REG_BASE_REPEAT:   repeat_cfg    = v & 32'h3f;
         prs_pkg::REG_REPEAT_STEP:   step_cfg      = v & 32'hfff;
         default: ;
      endcase
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic set_row_regs(int unsigned planes, int unsigned src, int unsigned dst,
                               int unsigned base, int unsigned step);
      wait_all_bytes();
      csr_write(prs_pkg::REG_PLANE_COUNT, planes);
      csr_write(prs_pkg::REG_SOURCE_PIXELS, src);
      csr_write(prs_pkg::REG_DEST_PIXELS, dst);
      csr_write(prs_pkg::REG_BASE_REPEAT, base);
      csr_write(prs_pkg::REG_REPEAT_STEP, step);
      settings_count++;
   endtask

   // ---- tests ----

   task automatic test_pattern_load();
      req_word_type w;
      for (int i = 0; i < 2 * prs_pkg::PATTERN_COLORS; i++) begin
         w = make_word(prs_pkg::CMD_LOAD);
         // phase 0 entries, then phase 7 entries
         w.pattern_index = (i < prs_pkg::PATTERN_COLORS) ? 7'(i) : 7'(i + 96);
         if (i == 0)
            w.pattern_value = 8'hff;
         else if (i == 2 * prs_pkg::PATTERN_COLORS - 1)
            w.pattern_value = 8'h00;
         send_word(w);
      end
   endtask

   // pixels ahead of any start word run with the reset row state
   task automatic test_pixels_before_start();
      set_row_regs(4, 16, 128, 3, 5);
      repeat (4) send_cmd(prs_pkg::CMD_PIXEL, $urandom);
      send_cmd(prs_pkg::CMD_END, 0);
   endtask

   task automatic test_register_extremes();
      // widest source, clipped destination, longest runs
      set_row_regs(4, 8191, 32767, 63, 4095);
      send_cmd(prs_pkg::CMD_START, 7);
      send_cmd(prs_pkg::CMD_PIXEL, 15);
      send_cmd(prs_pkg::CMD_PIXEL, 0);
      send_cmd(prs_pkg::CMD_PIXEL, 15);
      send_cmd(prs_pkg::CMD_END, 0);
      send_cmd(prs_pkg::CMD_END, 0);
      send_cmd(prs_pkg::CMD_PIXEL, 15);
      // step not below the source width
      set_row_regs(2, 5, 200, 2, 4095);
      send_row(3, 4);
   endtask

   task automatic test_invalid_settings();
      set_row_regs(0, 5, 64, 2, 1);
      send_cmd(prs_pkg::CMD_START, 1);
      send_cmd(prs_pkg::CMD_PIXEL, 15);
      send_cmd(prs_pkg::CMD_END, 0);
      set_row_regs(7, 5, 64, 2, 1);
      send_cmd(prs_pkg::CMD_PIXEL, 9);
      set_row_regs(3, 0, 64, 2, 1);
      send_cmd(prs_pkg::CMD_PIXEL, 6);
      send_cmd(prs_pkg::CMD_END, 0);
   endtask

   task automatic test_row_exhausted();
      // destination fills after three pixels
      set_row_regs(1, 6, 10, 4, 0);
      send_row(2, 5);
      // source runs out before the extra pixels
      set_row_regs(3, 3, 100, 4, 1);
      send_row(5, 5);
   endtask

   task automatic test_steady_stream();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_row_regs(4, 20, 300, 5, 13);
      send_row($urandom, 10);
      wait_all_bytes();
      req_idle_pct = 37;
      rsp_idle_pct = 37;
   endtask

   task automatic test_backpressure();
      set_row_regs(4, 40, 4000, 40, 7);
      rsp_hold_cycles = 300;
      send_row($urandom, 12);
      wait_all_bytes();
   endtask

   task automatic pick_random_regs();
      int unsigned planes, src, dst, base, step;
      int unsigned r;
      r = $urandom_range(99);
      planes = (r < 8) ? 0 : (r < 14) ? $urandom_range(5, 7) : $urandom_range(1, 4);
      r = $urandom_range(99);
      src = (r < 6) ? 0 : (r < 10) ? $urandom_range(4097, 8191) :
            (r < 14) ? 4096 : $urandom_range(1, 24);
      r = $urandom_range(99);
      base = (r < 10) ? $urandom_range(32, 63) : $urandom_range(0, 12);
      r = $urandom_range(99);
      if (r < 15 || src == 0)
         step = $urandom_range(0, 4095);
      else
         step = $urandom_range(0, (src > 4096 ? 4096 : src) - 1);
      r = $urandom_range(99);
      dst = (r < 8) ? $urandom_range(16385, 32767) : (r < 14) ? 16384 :
            (r < 20) ? $urandom_range(0, 16) : $urandom_range(0, 400);
      set_row_regs(planes, src, dst, base, step);
   endtask

   // mostly well-formed rows, with stray words and dropped end words mixed in
   task automatic test_random_rows();
      int start_acting;
      int npix;
      start_acting = words_acting;
      while (words_acting - start_acting < 15) begin
         pick_random_regs();
         repeat ($urandom_range(1, 3)) begin
            send_cmd(prs_pkg::CMD_START, $urandom);
            npix = (src_width_cfg <= 32) ? $urandom_range(0, src_width_cfg + 2)
                                         : $urandom_range(1, 12);
            repeat (npix) begin
               if ($urandom_range(99) < 12)
                  send_word(make_word(prs_pkg::cmd_type'($urandom_range(3))));
               send_cmd(prs_pkg::CMD_PIXEL, $urandom);
               if ($urandom_range(99) < 4)
                  wait_all_bytes();
            end
            if ($urandom_range(99) < 85)
               send_cmd(prs_pkg::CMD_END, 0);
         end
      end
   endtask

   // ---- result side ----

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_if.ready = 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_if.ready = ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_bytes
      dest_byte_type act;
      dest_byte_type exp;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         act.out_byte   = rsp_if.out_byte;
         act.byte_index = rsp_if.byte_index;
         act.last       = rsp_if.last;
         bytes_checked++;
         if (pending_bytes.size() == 0) begin
            flag_error($sformatf("unexpected byte %02h index %0d last %0b",
                                 act.out_byte, act.byte_index, act.last));
         end else begin
            exp = pending_bytes.pop_front();
            if (act.out_byte !== exp.out_byte || act.byte_index !== exp.byte_index ||
                act.last !== exp.last)
               flag_error($sformatf({"byte mismatch: expected %02h index %0d last %0b,",
                                     " got %02h index %0d last %0b"},
                                    exp.out_byte, exp.byte_index, exp.last,
                                    act.out_byte, act.byte_index, act.last));
         end
      end
   end

   initial begin
      reset                = 1'b1;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_if.valid         = 1'b0;
      req_if.cmd           = prs_pkg::CMD_LOAD;
      req_if.pattern_index = '0;
      req_if.pattern_value = '0;
      req_if.row_phase     = '0;
      req_if.plane_bits    = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      test_pattern_load();
      test_pixels_before_start();
      test_register_extremes();
      test_invalid_settings();
      test_row_exhausted();
      test_steady_stream();
      test_backpressure();
      test_random_rows();

      wait_all_bytes();
      repeat (30) @(posedge clock);
      if (pending_bytes.size() != 0)
         flag_error($sformatf("%0d bytes never arrived", pending_bytes.size()));
      $display("covered %0d words (%0d acting on row state) over %0d register settings",
               words_sent, words_acting, settings_count);
      $display("checked %0d destination bytes, %0d errors", bytes_checked, errors);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
